@@ rtl/clc_pkg.sv @@
package clc_pkg;

	localparam int NumBits   = 54;
	localparam int NumDigits = 17;
	localparam int BcdW      = 4 * NumDigits;
	localparam int DataInW   = 56;
	localparam int DataOutW  = 8;
	localparam int CntW      = 6;

	typedef enum logic [1:0] {
		KIND_INVALID,
		KIND_MC,
		KIND_AMEX,
		KIND_VISA
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_CLASS,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic dig_shift;
	} dp_ctrl_t;

	// Luhn doubling: 2*d, with the two digits of the product summed
	function automatic logic [3:0] dbl_digit(input logic [3:0] d);
		logic [4:0] t;
		t = {d, 1'b0};
		if (t >= 5'd10) begin
			t = t - 5'd9;
		end
		return t[3:0];
	endfunction

endpackage

@@ rtl/clc_bcd_conv.sv @@
module clc_bcd_conv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  clc_pkg::dp_ctrl_t               ctrl,
	input  logic [clc_pkg::NumBits-1:0]     number,
	output logic [3:0]                      digit,
	output clc_pkg::kind_t                  kind
);
	import clc_pkg::*;

	logic [NumBits-1:0] bin_q;
	logic [BcdW-1:0]    bcd_q;
	logic [BcdW-1:0]    adj;
	logic [3:0]         d16, d15, d14, d13, d12;
	logic               top_zero;

	// add-3 on every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                          : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
			bin_q <= '0;
		end else if (ctrl.load) begin
			bcd_q <= '0;
			bin_q <= number;
		end else if (ctrl.conv_step) begin
			bcd_q <= {adj[BcdW-2:0], bin_q[NumBits-1]};
			bin_q <= {bin_q[NumBits-2:0], 1'b0};
		end else if (ctrl.dig_shift) begin
			bcd_q <= {4'd0, bcd_q[BcdW-1:4]};
		end
	end

	assign digit = bcd_q[3:0];

	assign d16 = bcd_q[4*16 +: 4];
	assign d15 = bcd_q[4*15 +: 4];
	assign d14 = bcd_q[4*14 +: 4];
	assign d13 = bcd_q[4*13 +: 4];
	assign d12 = bcd_q[4*12 +: 4];
	assign top_zero = (d16 == 4'd0) && (d15 == 4'd0) && (d14 == 4'd0) && (d13 == 4'd0);

	// decimal length and leading digits stand in for the range compares
	always_comb begin
		kind = KIND_INVALID;
		if (d16 == 4'd0 && d15 == 4'd5 && d14 >= 4'd1 && d14 <= 4'd5) begin
			kind = KIND_MC;
		end else if (d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd3 &&
		             (d13 == 4'd4 || d13 == 4'd7)) begin
			kind = KIND_AMEX;
		end else if ((d16 == 4'd0 && d15 == 4'd4) || (top_zero && d12 == 4'd4)) begin
			kind = KIND_VISA;
		end
	end

	function automatic logic bcd_valid(input logic [BcdW-1:0] b);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < NumDigits; i++) begin
			if (b[4*i +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_valid(bcd_q))
		else $error("BCD digit out of range");

	a_bin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.dig_shift |-> bin_q == '0)
		else $error("digits read before conversion finished");

endmodule

@@ rtl/clc_luhn_acc.sv @@
module clc_luhn_acc (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clr,
	input  logic       en,
	input  logic       odd_pos,
	input  logic [3:0] digit,
	output logic       ok
);
	import clc_pkg::*;

	logic [3:0] acc_q;
	logic [3:0] val;
	logic [4:0] sum;
	logic [4:0] sum_m;

	assign val   = odd_pos ? dbl_digit(digit) : digit;
	assign sum   = {1'b0, acc_q} + {1'b0, val};
	assign sum_m = (sum >= 5'd10) ? sum - 5'd10 : sum;

	// running digit sum kept modulo ten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= sum_m[3:0];
		end
	end

	assign ok = (acc_q == 4'd0);

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= 4'd9)
		else $error("Luhn accumulator out of range");

endmodule

@@ rtl/card_number_luhn_classifier_top.sv @@
// Luhn mod-10 card number checker and classifier.
// Input: s_tvalid/s_tready/s_tdata carry one binary card number per transfer.
// Output: m_tvalid/m_tready/m_tdata carry one result per input: the card
// kind (0 invalid, 1 mastercard, 2 amex, 3 visa) and the Luhn pass flag.
// Kind is forced to invalid when the Luhn check fails.
// Each number is converted to 17 BCD digits by shift-and-add-3, one bit per
// cycle, classified in the ST_CLASS state, then its digits are fed one per
// cycle to a single mod-10 accumulator. The result is loaded into the output
// register from ST_DONE; s_tready is high only while the sequencer is idle,
// so a new number is taken only once the previous result has left the
// sequencer.
// The output register holds a result until taken; a new number is accepted
// while it waits, and a finished result stalls in the sequencer until the
// output register is free.
// Reset clears sequencer, converter, accumulator and m_tvalid, not the data.
module card_number_luhn_classifier_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [clc_pkg::DataInW-1:0]     s_tdata,  // [53:0] card_number
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [clc_pkg::DataOutW-1:0]    m_tdata   // [1:0] card_kind, [2] luhn_ok
);
	import clc_pkg::*;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            cnt_clr, cnt_inc;
	dp_ctrl_t        ctrl;
	logic [3:0]      digit;
	kind_t           kind_c;
	kind_t           kind_q;
	logic            luhn_ok;
	logic            acc_clr;
	logic            class_en;
	logic            out_load;
	logic            out_free;
	logic            m_tvalid_q;
	kind_t           kind_out_q;
	logic            ok_out_q;
	logic            accept;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_CONV;
			ST_CONV:  if (cnt_q == CntW'(NumBits - 1)) state_d = ST_CLASS;
			ST_CLASS: state_d = ST_SUM;
			ST_SUM:   if (cnt_q == CntW'(NumDigits - 1)) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		ctrl.load      = 1'b0;
		ctrl.conv_step = 1'b0;
		ctrl.dig_shift = 1'b0;
		cnt_clr        = 1'b0;
		cnt_inc        = 1'b0;
		acc_clr        = 1'b0;
		class_en       = 1'b0;
		out_load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ctrl.load = s_tvalid;
				cnt_clr   = 1'b1;
				acc_clr   = 1'b1;
			end
			ST_CONV: begin
				ctrl.conv_step = 1'b1;
				cnt_inc        = 1'b1;
			end
			ST_CLASS: begin
				class_en = 1'b1;
				cnt_clr  = 1'b1;
			end
			ST_SUM: begin
				ctrl.dig_shift = 1'b1;
				cnt_inc        = 1'b1;
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (class_en) begin
			kind_q <= kind_c;
		end
	end

	clc_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.number (s_tdata[NumBits-1:0]),
		.digit  (digit),
		.kind   (kind_c)
	);

	clc_luhn_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (acc_clr),
		.en      (ctrl.dig_shift),
		.odd_pos (cnt_q[0]),
		.digit   (digit),
		.ok      (luhn_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_out_q <= luhn_ok ? kind_q : KIND_INVALID;
			ok_out_q   <= luhn_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(DataOutW - 3){1'b0}}, ok_out_q, kind_out_q};

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CONV && cnt_q == '0)
		else $error("conversion did not start after input transfer");

	a_sum_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM && cnt_q == CntW'(NumDigits - 1) |=> state_q == ST_DONE)
		else $error("digit sum did not end after last digit");

	a_fail_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[1:0] == KIND_INVALID)
		else $error("kind reported for a number failing Luhn");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_tvalid_q || m_tready)
		else $error("pending result overwritten");

endmodule
